FILE: sv/progress_monotonic_tracker_defines.svh
// Assertion macros for the progress tracker.
`ifndef PROGRESS_MONOTONIC_TRACKER_DEFINES_SVH
`define PROGRESS_MONOTONIC_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define PMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMT_ASSERT_IMP(lbl, ante, cons, msg)
`define PMT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/pmt_pkg.sv
package pmt_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;

  localparam int unsigned STREAM_W   = 32;
  localparam int unsigned EPOCH_W    = 64;
  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned SCOUNT_W   = 7;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_DATA_W  = STREAM_W + EPOCH_W + SEQ_W + BYTES_W;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_NEW       = 3'd0,
    VERDICT_UPDATED   = 3'd1,
    VERDICT_OVER      = 3'd2,
    VERDICT_REGRESSED = 3'd3,
    VERDICT_EXTERNAL  = 3'd4
  } verdict_e;

  typedef struct packed {
    logic                valid;
    logic [STREAM_W-1:0] stream;
    logic [EPOCH_W-1:0]  epoch;
    logic [SEQ_W-1:0]    seq;
    logic [BYTES_W-1:0]  bytes;
  } entry_t;

endpackage

FILE: sv/progress_monotonic_tracker.sv
// Progress tracker: checks each progress report (stream, epoch, sequence, bytes filled) against
// a table of DEPTH tracked frames and returns one verdict beat per report. After reset every
// table entry is swept clear with s_axis_tready low. A report over a nonzero byte limit
// is answered in the cycle after it is taken. In associative mode (slot_count zero) the table
// memory is read one entry a cycle from entry 0, stopping early on a hit. In direct mode
// the slot is the masked sequence reduced modulo DEPTH by repeated subtraction, and then one
// entry is read. One report is in flight at a time; the next is taken once the verdict beat
// has left.
`include "progress_monotonic_tracker_defines.svh"

module progress_monotonic_tracker #(
  parameter int unsigned DEPTH = pmt_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pmt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // stream_number[31:0], epoch_number[95:32], frame_sequence[159:96], bytes_filled[191:160]
  input  logic [pmt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // external_ok
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // verdict[2:0], accepted[3], slot_touched[9:4], zero pad[15:10]
  output logic [pmt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned RW  = (AW + 1 > pmt_pkg::SCOUNT_W) ? AW + 1 : pmt_pkg::SCOUNT_W;
  localparam int unsigned SXW = (AW > pmt_pkg::SLOT_OUT_W) ? AW : pmt_pkg::SLOT_OUT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e state_q;

  logic [pmt_pkg::CFG_DATA_W-1:0] byte_limit_q;
  logic [pmt_pkg::SCOUNT_W-1:0]   slot_count_q;

  logic [pmt_pkg::STREAM_W-1:0] it_stream_q;
  logic [pmt_pkg::EPOCH_W-1:0]  it_epoch_q;
  logic [pmt_pkg::SEQ_W-1:0]    it_seq_q;
  logic [pmt_pkg::BYTES_W-1:0]  it_bytes_q;
  logic                         it_ext_q;
  logic                         direct_q;

  logic [RW-1:0]  red_q;
  logic [AW-1:0]  idx_q;
  logic [CW-1:0]  left_q;
  logic           pend_q;
  logic [AW-1:0]  pidx_q;
  logic [AW-1:0]  cursor_q;
  logic           hit_q;
  logic [AW-1:0]  slot_q;
  logic [pmt_pkg::BYTES_W-1:0] ent_bytes_q;

  logic              m_tvalid_q;
  pmt_pkg::verdict_e verdict_q;

  pmt_pkg::entry_t mem_q [DEPTH];
  pmt_pkg::entry_t rdata_q;

  logic [pmt_pkg::STREAM_W-1:0] in_stream;
  logic [pmt_pkg::EPOCH_W-1:0]  in_epoch;
  logic [pmt_pkg::SEQ_W-1:0]    in_seq;
  logic [pmt_pkg::BYTES_W-1:0]  in_bytes;
  logic                         in_acc;
  logic                         hit_now;
  logic                         do_write;
  pmt_pkg::verdict_e            verdict_dec;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  pmt_pkg::entry_t              mem_wd;
  logic [AW:0]                  cursor_inc;
  logic [SXW-1:0]               slot_ext;
  logic                         accepted;

  assign in_stream = s_axis_tdata[31:0];
  assign in_epoch  = s_axis_tdata[95:32];
  assign in_seq    = s_axis_tdata[159:96];
  assign in_bytes  = s_axis_tdata[191:160];

  assign s_axis_tready = (state_q == ST_IDLE) && !m_tvalid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign hit_now = pend_q && rdata_q.valid && (rdata_q.seq == it_seq_q) &&
                   (rdata_q.stream == it_stream_q) && (rdata_q.epoch == it_epoch_q);

  always_comb begin
    do_write = 1'b0;
    if (hit_q && (it_bytes_q < ent_bytes_q)) begin
      verdict_dec = pmt_pkg::VERDICT_REGRESSED;
    end else if (!it_ext_q) begin
      verdict_dec = pmt_pkg::VERDICT_EXTERNAL;
    end else begin
      do_write    = 1'b1;
      verdict_dec = hit_q ? pmt_pkg::VERDICT_UPDATED : pmt_pkg::VERDICT_NEW;
    end
  end

  // a hit leaves the key fields equal, so both cases write the whole entry
  assign mem_we = (state_q == ST_CLEAR) || ((state_q == ST_DECIDE) && do_write);
  assign mem_wa = (state_q == ST_CLEAR) ? idx_q : slot_q;
  always_comb begin
    mem_wd        = '0;
    if (state_q != ST_CLEAR) begin
      mem_wd.valid  = 1'b1;
      mem_wd.stream = it_stream_q;
      mem_wd.epoch  = it_epoch_q;
      mem_wd.seq    = it_seq_q;
      mem_wd.bytes  = it_bytes_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[idx_q];
  end

  assign cursor_inc = {1'b0, slot_q} + (AW + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      byte_limit_q <= '0;
      slot_count_q <= '0;
      it_stream_q  <= '0;
      it_epoch_q   <= '0;
      it_seq_q     <= '0;
      it_bytes_q   <= '0;
      it_ext_q     <= 1'b0;
      direct_q     <= 1'b0;
      red_q        <= '0;
      idx_q        <= '0;
      left_q       <= '0;
      pend_q       <= 1'b0;
      pidx_q       <= '0;
      cursor_q     <= '0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      ent_bytes_q  <= '0;
      m_tvalid_q   <= 1'b0;
      verdict_q    <= pmt_pkg::VERDICT_NEW;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pmt_pkg::REG_BYTE_LIMIT: byte_limit_q <= cfg_data_i;
          pmt_pkg::REG_SLOT_COUNT: slot_count_q <= cfg_data_i[pmt_pkg::SCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + AW'(1);
          if (idx_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            it_stream_q <= in_stream;
            it_epoch_q  <= in_epoch;
            it_seq_q    <= in_seq;
            it_bytes_q  <= in_bytes;
            it_ext_q    <= s_axis_tuser;
            pend_q      <= 1'b0;
            if ((byte_limit_q != '0) && (in_bytes > byte_limit_q)) begin
              m_tvalid_q <= 1'b1;
              verdict_q  <= pmt_pkg::VERDICT_OVER;
              slot_q     <= '0;
            end else if (slot_count_q != '0) begin
              direct_q <= 1'b1;
              red_q    <= RW'(in_seq[pmt_pkg::SCOUNT_W-1:0] &
                              (slot_count_q - pmt_pkg::SCOUNT_W'(1)));
              state_q  <= ST_REDUCE;
            end else begin
              direct_q <= 1'b0;
              idx_q    <= '0;
              left_q   <= CW'(DEPTH);
              state_q  <= ST_SCAN;
            end
          end
        end
        ST_REDUCE: begin
          if (red_q >= RW'(DEPTH)) begin
            red_q <= red_q - RW'(DEPTH);
          end else begin
            idx_q   <= red_q[AW-1:0];
            left_q  <= CW'(1);
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (left_q != '0) begin
            pend_q <= 1'b1;
            pidx_q <= idx_q;
            idx_q  <= idx_q + AW'(1);
            left_q <= left_q - CW'(1);
          end else begin
            pend_q <= 1'b0;
          end
          if (hit_now) begin
            hit_q       <= 1'b1;
            slot_q      <= pidx_q;
            ent_bytes_q <= rdata_q.bytes;
            state_q     <= ST_DECIDE;
          end else if (pend_q && (left_q == '0)) begin
            hit_q   <= 1'b0;
            slot_q  <= direct_q ? pidx_q : cursor_q;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          m_tvalid_q <= 1'b1;
          verdict_q  <= verdict_dec;
          state_q    <= ST_IDLE;
          if (do_write && !hit_q && !direct_q) begin
            cursor_q <= (cursor_inc == (AW + 1)'(DEPTH)) ? '0 : cursor_inc[AW-1:0];
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign slot_ext      = SXW'(slot_q);
  assign accepted      = (verdict_q == pmt_pkg::VERDICT_NEW) ||
                         (verdict_q == pmt_pkg::VERDICT_UPDATED);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {6'b0, slot_ext[pmt_pkg::SLOT_OUT_W-1:0], accepted, verdict_q};

  `PMT_ASSERT_IMP(a_over_slot_zero, m_tvalid_q && (verdict_q == pmt_pkg::VERDICT_OVER), slot_q == '0, "over-limit verdict with nonzero slot")
  `PMT_ASSERT_NXT(a_cursor_hold, state_q != ST_DECIDE, $stable(cursor_q), "cursor moved outside decide")
  `PMT_ASSERT_IMP(a_scan_live, state_q == ST_SCAN, (left_q != '0) || pend_q, "scan stalled with nothing pending")
  `PMT_ASSERT_NXT(a_decide_emits, state_q == ST_DECIDE, m_tvalid_q && (state_q == ST_IDLE), "decide did not emit a beat")

endmodule
